// ===== rtl/aeske_pkg.sv =====
// shared types, constants and byte-substitution helpers for the aes-128 key expansion
// used by the key queue, the round engine and the top level; depends on nothing
package aeske_pkg;

   localparam int unsigned WordWidth    = 32;
   localparam int unsigned RoundWidth   = 4;
   localparam int unsigned QueueDepthDefault = 2;

   localparam logic [RoundWidth-1:0] RoundFirst = 4'd0;
   localparam logic [RoundWidth-1:0] RoundLast  = 4'd10;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type w3;
      word_type w2;
      word_type w1;
      word_type w0;
   } key_type;

   // queue to engine handshake
   typedef struct packed {
      logic    valid;
      key_type key;
   } key_slot_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   // substitute all four bytes of a word
   function automatic word_type sub_word(input word_type v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // round constant for the round that follows round r
   function automatic logic [7:0] rcon_after(input logic [RoundWidth-1:0] r);
      logic [7:0] c;
      c = 8'h00;
      case (r)
         4'd0: c = 8'h01;
         4'd1: c = 8'h02;
         4'd2: c = 8'h04;
         4'd3: c = 8'h08;
         4'd4: c = 8'h10;
         4'd5: c = 8'h20;
         4'd6: c = 8'h40;
         4'd7: c = 8'h80;
         4'd8: c = 8'h1B;
         4'd9: c = 8'h36;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/aeske_key_queue.sv =====
// front end: accepts cipher keys from the request channel into a short fifo
// depends on aeske_pkg
module aeske_key_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  aeske_pkg::key_type     push_key,
   output logic                   not_full,
   input  logic                   pop,
   output aeske_pkg::key_slot_type head
);
   import aeske_pkg::*;

   localparam int unsigned IdxWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [IdxWidth-1:0] IdxLast = IdxWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   key_type               slot_ff [Depth];
   logic [IdxWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IdxWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign not_full = (count_ff != CntFull);
   assign do_push  = push && not_full;
   assign do_pop   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.key   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IdxLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_key;
      end
   end

endmodule

// ===== rtl/aeske_round_engine.sv =====
// back end: expands one key into eleven round keys, one per cycle while out_ready is high, into the output register
// depends on aeske_pkg
module aeske_round_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  aeske_pkg::key_slot_type       head,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [aeske_pkg::RoundWidth-1:0] out_round,
   output aeske_pkg::key_type            out_key,
   output logic                          out_last
);
   import aeske_pkg::*;

   logic                  valid_ff, valid_in;
   logic [RoundWidth-1:0] round_ff, round_in;
   key_type               key_ff, key_in;
   logic                  last;
   logic                  step;
   word_type              temp;
   key_type               next_key;

   assign last = (round_ff == RoundLast);

   // next round words from the one now on the output
   always_comb begin
      temp       = sub_word({key_ff.w3[23:0], key_ff.w3[31:24]})
                   ^ {rcon_after(round_ff), 24'h000000};
      next_key.w0 = key_ff.w0 ^ temp;
      next_key.w1 = key_ff.w1 ^ next_key.w0;
      next_key.w2 = key_ff.w2 ^ next_key.w1;
      next_key.w3 = key_ff.w3 ^ next_key.w2;
   end

   assign step = valid_ff && out_ready && !last;
   assign pop  = head.valid && (!valid_ff || (out_ready && last));

   always_comb begin
      valid_in = valid_ff;
      round_in = round_ff;
      key_in   = key_ff;
      if (pop) begin
         valid_in = 1'b1;
         round_in = RoundFirst;
         key_in   = head.key;
      end else if (step) begin
         round_in = round_ff + 1'b1;
         key_in   = next_key;
      end else if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         round_ff <= RoundFirst;
      end else begin
         valid_ff <= valid_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign out_valid = valid_ff;
   assign out_round = round_ff;
   assign out_key   = key_ff;
   assign out_last  = last;

endmodule

// ===== rtl/aes128_key_expansion.sv =====
// aes-128 key expansion: one key in, eleven round keys out, one per cycle while rsp_tready is high
// a key is written into the fifo, then loaded into the output register as round 0 once the engine is free
// throughput: one round key a cycle while rsp_tready is high, set by the single round engine
// the key fifo (QueueDepth entries) takes new keys while the engine is busy
// reset: synchronous, clears the fifo pointers and the output valid, no clearing pass
// depends on aeske_pkg, aeske_key_queue and aeske_round_engine
module aes128_key_expansion #(
   parameter int unsigned QueueDepth = aeske_pkg::QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   // request channel: one cipher key per transfer
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // key_word0, key_word1, key_word2, key_word3
   // response channel: one round key per transfer
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // round_word0, round_word1, round_word2, round_word3
   output logic [3:0]   rsp_tuser,   // round_number
   output logic         rsp_tlast    // last_round
);
   import aeske_pkg::*;

   key_type      req_key;
   key_slot_type head;
   logic         pop;
   key_type      out_key;

   // word 0 sits in the low bits of tdata
   assign req_key.w0 = req_tdata[31:0];
   assign req_key.w1 = req_tdata[63:32];
   assign req_key.w2 = req_tdata[95:64];
   assign req_key.w3 = req_tdata[127:96];

   // front end: key fifo
   aeske_key_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_tvalid),
      .push_key (req_key),
      .not_full (req_tready),
      .pop      (pop),
      .head     (head)
   );

   // back end: round generation straight into the output register
   aeske_round_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_round (rsp_tuser),
      .out_key   (out_key),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {out_key.w3, out_key.w2, out_key.w1, out_key.w0};

   // a round key that is not the last is followed at once by the next round
   a_round_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 4'd1))
      else $error("round sequence broken");

   // after the last round the next result, if any, starts a new key
   a_new_key_at_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast
      |=> !rsp_tvalid || (rsp_tuser == RoundFirst))
      else $error("new key does not start at round 0");

   // round number never runs past the final round
   a_round_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= RoundLast))
      else $error("round number out of range");

endmodule

// ===== dv/aeske_tb_pkg.sv =====
// scoreboard for the aes-128 key expansion testbench: expands each accepted key into
// its eleven round keys and checks every round key transfer in order
// depends on aeske_pkg for the word type
package aeske_tb_pkg;

   import aeske_pkg::word_type;

   localparam int unsigned RoundKeyCount = 11;

   typedef struct packed {
      logic [3:0] round_number;
      word_type   round_word0;
      word_type   round_word1;
      word_type   round_word2;
      word_type   round_word3;
      logic       last_round;
   } round_key_type;

   class round_key_scoreboard;

      round_key_type expected_round_keys[$];
      logic [7:0]    sub_table[256];
      logic [7:0]    round_consts[10];
      bit            failed;

      // s-box derived from the gf(2^8) inverse and the affine map, round constants by repeated doubling
      function new();
         logic [7:0] a, b, p, inv, c;
         failed = 1'b0;
         for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256 && x != 0; y++) begin
               a = x[7:0];
               b = y[7:0];
               p = 8'h00;
               for (int k = 0; k < 8; k++) begin
                  if (b[0]) p = p ^ a;
                  a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
                  b = b >> 1;
               end
               if (p == 8'h01) inv = y[7:0];
            end
            sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         end
         c = 8'h01;
         for (int i = 0; i < 10; i++) begin
            round_consts[i] = c;
            c = {c[6:0], 1'b0} ^ (c[7] ? 8'h1B : 8'h00);
         end
      endfunction

      function void note_key(logic [127:0] key);
         word_type      w[4];
         word_type      t;
         round_key_type rk;
         for (int j = 0; j < 4; j++) w[j] = key[32*j +: 32];
         for (int r = 0; r < RoundKeyCount; r++) begin
            if (r > 0) begin
               // rotate left one byte, substitute, fold in the round constant
               t = {sub_table[w[3][23:16]], sub_table[w[3][15:8]],
                    sub_table[w[3][7:0]], sub_table[w[3][31:24]]};
               t = t ^ {round_consts[r-1], 24'h000000};
               w[0] = w[0] ^ t;
               w[1] = w[1] ^ w[0];
               w[2] = w[2] ^ w[1];
               w[3] = w[3] ^ w[2];
            end
            rk.round_number = r[3:0];
            rk.round_word0  = w[0];
            rk.round_word1  = w[1];
            rk.round_word2  = w[2];
            rk.round_word3  = w[3];
            rk.last_round   = (r == RoundKeyCount - 1);
            expected_round_keys.insert(expected_round_keys.size(), rk);
         end
      endfunction

      function void check_round_key(logic [3:0] round_number, logic [127:0] words,
                                    logic last_round);
         round_key_type want;
         word_type      got_word;
         word_type      want_word;
         if (expected_round_keys.size() == 0) begin
            $error("round key transfer with nothing expected, round_number %0d", round_number);
            failed = 1'b1;
            return;
         end
         want = expected_round_keys.pop_front();
         if (round_number !== want.round_number) begin
            $error("round_number: expected %0d, actual %0d", want.round_number, round_number);
            failed = 1'b1;
         end
         for (int j = 0; j < 4; j++) begin
            got_word = words[32*j +: 32];
            case (j)
               0: want_word = want.round_word0;
               1: want_word = want.round_word1;
               2: want_word = want.round_word2;
               default: want_word = want.round_word3;
            endcase
            if (got_word !== want_word) begin
               $error("round_word%0d (round %0d): expected %h, actual %h",
                      j, want.round_number, want_word, got_word);
               failed = 1'b1;
            end
         end
         if (last_round !== want.last_round) begin
            $error("last_round (round %0d): expected %b, actual %b",
                   want.round_number, want.last_round, last_round);
            failed = 1'b1;
         end
      endfunction

      function int pending_count();
         return expected_round_keys.size();
      endfunction

   endclass

endpackage

// ===== dv/testbench.sv =====
// top level of the aes-128 key expansion testbench: clock, reset, key sender and
// round key receiver around one instance of aes128_key_expansion
// depends on aeske_pkg, aeske_tb_pkg and the rtl of the block
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import aeske_tb_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // key_word0, key_word1, key_word2, key_word3
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // round_word0, round_word1, round_word2, round_word3
   logic [3:0]   rsp_tuser;        // round_number
   logic         rsp_tlast;        // last_round

   round_key_scoreboard board = new();

   // receiver behavior, set by the stimulus process
   int rsp_stall_pct = 0;
   int long_hold_cycles = 0;
   int long_hold_tag = 0;

   aes128_key_expansion i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs or drops round keys
   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // each word is mostly random, sometimes all zeros or all ones
   function automatic logic [127:0] random_key();
      logic [127:0] k;
      for (int j = 0; j < 4; j++) begin
         case ($urandom_range(7))
            0: k[32*j +: 32] = 32'h00000000;
            1: k[32*j +: 32] = 32'hFFFFFFFF;
            default: k[32*j +: 32] = $urandom;
         endcase
      end
      return k;
   endfunction

   // offer one key after a random number of idle cycles, return at its transfer
   task automatic send_key(input logic [127:0] key, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_key(key);
   endtask

   // sender goes quiet until every expected round key has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_count() != 0) @(posedge clock);
   endtask

   // receiver: checks each round key transfer and picks tready for the next cycle;
   // a long hold is counted down here once the stimulus asks for one
   initial begin : round_key_sink
      int hold_left;
      int tag_seen;
      hold_left = 0;
      tag_seen  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_round_key(rsp_tuser, rsp_tdata, rsp_tlast);
         end
         if (long_hold_tag != tag_seen) begin
            tag_seen  = long_hold_tag;
            hold_left = long_hold_cycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : stimulus
      logic [127:0] directed_keys[$];
      int           sender_idle[4];
      int           receiver_stall[4];

      // idling phases: none, sender slow, receiver slow, both a little
      sender_idle    = '{0, 82, 0, 12};
      receiver_stall = '{0, 0, 82, 12};

      // extremes, the standard test key and a few bit patterns
      directed_keys = '{
         128'h00000000_00000000_00000000_00000000,
         128'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF,
         {32'h09cf4f3c, 32'habf71588, 32'h28aed2a6, 32'h2b7e1516},
         {32'h0c0d0e0f, 32'h08090a0b, 32'h04050607, 32'h00010203},
         128'h55555555_55555555_55555555_55555555,
         128'hAAAAAAAA_AAAAAAAA_AAAAAAAA_AAAAAAAA,
         128'h00000000_00000000_00000000_FFFFFFFF,
         128'h00000000_00000000_FFFFFFFF_00000000,
         128'h00000000_FFFFFFFF_00000000_00000000,
         128'hFFFFFFFF_00000000_00000000_00000000,
         128'h80000000_00000000_00000000_00000001,
         128'h01020408_10204080_FEFDFBF7_EFDFBF7F
      };

      // reset held at the start, then released with a quiet wait before the first key
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed keys back to back, receiver always ready
      foreach (directed_keys[i]) send_key(directed_keys[i], 0);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         rsp_stall_pct = receiver_stall[p];
         for (int i = 0; i < 115; i++) send_key(random_key(), sender_idle[p]);
         wait_drained();
      end

      // long receiver hold while keys keep coming, so the key fifo fills and
      // req_tready drops; the sender then waits for all round keys
      rsp_stall_pct    = 0;
      long_hold_cycles = 200;
      long_hold_tag    = long_hold_tag + 1;
      for (int i = 0; i < 10; i++) send_key(random_key(), 0);
      wait_drained();

      // a few more keys with light idling on both sides
      rsp_stall_pct = 12;
      for (int i = 0; i < 10; i++) send_key(random_key(), 12);
      wait_drained();

      // allow any stray transfer to show up before the verdict
      repeat (30) @(posedge clock);
      if (!board.failed) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
